// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL that carries concurrent checks.
// Needs a clk and an active-low rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on clk, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/rrao_pkg.sv =====
// Shared widths, types and helpers for the rotated rect / box overlap test.
// No dependencies.
package rrao_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int NORM_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = COORD_WIDTH + NORM_WIDTH;
    localparam int DOT_WIDTH   = PROD_WIDTH + 1;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_POINTS  = 2 * NUM_CORNERS;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [NORM_WIDTH-1:0]  norm_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [DOT_WIDTH-1:0]   dot_t;

    // One input item as captured at the port.
    typedef struct packed {
        coord_t [NUM_CORNERS-1:0] cx;
        coord_t [NUM_CORNERS-1:0] cy;
        coord_t                   box_left;
        coord_t                   box_right;
        coord_t                   box_top;
        coord_t                   box_bottom;
    } raw_item_t;

    // Quad corners 0..3 then box corners, both edge normals and the extent-test flag.
    typedef struct packed {
        coord_t [NUM_POINTS-1:0] px;
        coord_t [NUM_POINTS-1:0] py;
        norm_t                   n0x;
        norm_t                   n0y;
        norm_t                   n1x;
        norm_t                   n1y;
        logic                    ext_hit;
    } front_t;

    // Load enables for the projection stages.
    typedef struct packed {
        logic load_prod;
        logic load_range;
    } pipe_ctrl_t;

    function automatic coord_t coord_min(coord_t a, coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t coord_max(coord_t a, coord_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic dot_t dot_min(dot_t a, dot_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic dot_t dot_max(dot_t a, dot_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/core/rotated_rect_aabb_overlap_test.sv =====
// Rotated rectangle vs axis-aligned box overlap (2D separating-axis test).
// Input channel: item_valid / item_stall with the four quad corners and the
// four box edges, each a signed COORD_WIDTH fixed-point port. A transfer
// happens at a rising edge with item_valid high and item_stall low.
// Output channel: result_valid / result_stall with the one-bit overlaps flag,
// one result per input item, in order. Touching counts as overlap.
// Stages, in order: input register, front stage, product stage, min/max
// stage, result register. Throughput: one item per cycle unless stalled,
// set by the fully parallel product stage (16 multipliers per axis, 32 in
// all); up to five items are in flight. Each stage holds its item only
// while the stage after it is full and blocked, so bubbles collapse and
// the input keeps being taken while a finished result waits. item_stall
// rises only once every stage is full and result_stall is high; it follows
// result_stall in the same cycle.
// Reset (rst_n low, asynchronous) empties the pipeline: all valid flags
// clear, result_valid drops. There is no configuration and no stored state
// that outlives an item.
// Depends on rrao_pkg, rrao_front, rrao_axis and assert_macros.svh.
`include "assert_macros.svh"

module rotated_rect_aabb_overlap_test
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  rrao_pkg::coord_t corner0_x,
    input  rrao_pkg::coord_t corner0_y,
    input  rrao_pkg::coord_t corner1_x,
    input  rrao_pkg::coord_t corner1_y,
    input  rrao_pkg::coord_t corner2_x,
    input  rrao_pkg::coord_t corner2_y,
    input  rrao_pkg::coord_t corner3_x,
    input  rrao_pkg::coord_t corner3_y,
    input  rrao_pkg::coord_t box_left,
    input  rrao_pkg::coord_t box_right,
    input  rrao_pkg::coord_t box_top,
    input  rrao_pkg::coord_t box_bottom,
    output logic             result_valid,
    input  logic             result_stall,
    output logic             overlaps
);
    import rrao_pkg::*;

    raw_item_t  item_next;
    raw_item_t  item_reg;
    front_t     front;
    pipe_ctrl_t ctrl;

    // stage valid flags: input reg, front, products, min/max, result
    logic v0_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic result_valid_reg;

    // extent-test result travels beside the projection stages
    logic ext2_reg;
    logic ext3_reg;
    logic overlaps_next;
    logic overlaps_reg;

    logic ok0;
    logic ok1;

    // a stage may load when empty or when its content moves on
    logic rdy0;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    always_comb
    begin
        rdy4 = !result_valid_reg || !result_stall;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        rdy0 = !v0_reg || rdy1;
    end

    assign item_stall = !rdy0;

    always_comb
    begin
        item_next.cx[0]      = corner0_x;
        item_next.cy[0]      = corner0_y;
        item_next.cx[1]      = corner1_x;
        item_next.cy[1]      = corner1_y;
        item_next.cx[2]      = corner2_x;
        item_next.cy[2]      = corner2_y;
        item_next.cx[3]      = corner3_x;
        item_next.cy[3]      = corner3_y;
        item_next.box_left   = box_left;
        item_next.box_right  = box_right;
        item_next.box_top    = box_top;
        item_next.box_bottom = box_bottom;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg           <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= item_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                result_valid_reg <= v3_reg;
            end
        end
    end

    always_comb
    begin
        ctrl.load_prod  = v1_reg && rdy2;
        ctrl.load_range = v2_reg && rdy3;
    end

    rrao_front u_front
    (
        .clk   (clk),
        .load  (v0_reg && rdy1),
        .item  (item_reg),
        .front (front)
    );

    rrao_axis u_axis0
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .pts_x (front.px),
        .pts_y (front.py),
        .nx    (front.n0x),
        .ny    (front.n0y),
        .ok    (ok0)
    );

    rrao_axis u_axis1
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .pts_x (front.px),
        .pts_y (front.py),
        .nx    (front.n1x),
        .ny    (front.n1y),
        .ok    (ok1)
    );

    // a degenerate edge gives a zero normal, so that axis reports overlap
    assign overlaps_next = ext3_reg && ok0 && ok1;

    always_ff @(posedge clk)
    begin
        if (item_valid && rdy0)
        begin
            item_reg <= item_next;
        end
        if (ctrl.load_prod)
        begin
            ext2_reg <= front.ext_hit;
        end
        if (ctrl.load_range)
        begin
            ext3_reg <= ext2_reg;
        end
        if (v3_reg && rdy4)
        begin
            overlaps_reg <= overlaps_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign overlaps     = overlaps_reg;

    // input is held off only when every stage is full and the output blocked
    `ASSERT_CLK(a_stall_full, item_stall |-> (v0_reg && v1_reg && v2_reg && v3_reg && result_valid_reg && result_stall), "input stalled with a free stage")
    // a failed extent test always yields a miss
    `ASSERT_CLK(a_extent_miss, (v3_reg && rdy4 && !ext3_reg) |=> !overlaps, "extent miss reported as overlap")
    // a new result only ever comes from the min/max stage
    `ASSERT_CLK(a_result_src, $rose(result_valid) |-> $past(v3_reg), "result without a source item")

endmodule

// ===== rtl/core/rrao_front.sv =====
// Front stage: box corners, quad extent test and both edge normals.
// Depends on rrao_pkg.
module rrao_front
(
    input  logic              clk,
    input  logic              load,
    input  rrao_pkg::raw_item_t item,
    output rrao_pkg::front_t  front
);
    import rrao_pkg::*;

    front_t front_next;
    front_t front_reg;
    coord_t qxmin;
    coord_t qxmax;
    coord_t qymin;
    coord_t qymax;

    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            front_next.px[i] = item.cx[i];
            front_next.py[i] = item.cy[i];
        end
        // box corners: (l,t) (r,t) (r,b) (l,b)
        front_next.px[4] = item.box_left;
        front_next.py[4] = item.box_top;
        front_next.px[5] = item.box_right;
        front_next.py[5] = item.box_top;
        front_next.px[6] = item.box_right;
        front_next.py[6] = item.box_bottom;
        front_next.px[7] = item.box_left;
        front_next.py[7] = item.box_bottom;

        qxmin = coord_min(coord_min($signed(item.cx[0]), $signed(item.cx[1])),
                          coord_min($signed(item.cx[2]), $signed(item.cx[3])));
        qxmax = coord_max(coord_max($signed(item.cx[0]), $signed(item.cx[1])),
                          coord_max($signed(item.cx[2]), $signed(item.cx[3])));
        qymin = coord_min(coord_min($signed(item.cy[0]), $signed(item.cy[1])),
                          coord_min($signed(item.cy[2]), $signed(item.cy[3])));
        qymax = coord_max(coord_max($signed(item.cy[0]), $signed(item.cy[1])),
                          coord_max($signed(item.cy[2]), $signed(item.cy[3])));

        // box edges taken as given, no swap for a malformed box
        front_next.ext_hit = (qxmax >= $signed(item.box_left))
                          && ($signed(item.box_right) >= qxmin)
                          && (qymax >= $signed(item.box_top))
                          && ($signed(item.box_bottom) >= qymin);

        // perpendiculars of edge 0->1 and edge 1->2
        front_next.n0x = norm_t'($signed(item.cy[0])) - norm_t'($signed(item.cy[1]));
        front_next.n0y = norm_t'($signed(item.cx[1])) - norm_t'($signed(item.cx[0]));
        front_next.n1x = norm_t'($signed(item.cy[1])) - norm_t'($signed(item.cy[2]));
        front_next.n1y = norm_t'($signed(item.cx[2])) - norm_t'($signed(item.cx[1]));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

// ===== rtl/core/rrao_axis.sv =====
// One separating axis: products, dot sums with min/max, interval overlap.
// Depends on rrao_pkg.
module rrao_axis
(
    input  logic                                          clk,
    input  rrao_pkg::pipe_ctrl_t                          ctrl,
    input  rrao_pkg::coord_t [rrao_pkg::NUM_POINTS-1:0]   pts_x,
    input  rrao_pkg::coord_t [rrao_pkg::NUM_POINTS-1:0]   pts_y,
    input  rrao_pkg::norm_t                               nx,
    input  rrao_pkg::norm_t                               ny,
    output logic                                          ok
);
    import rrao_pkg::*;

    prod_t [NUM_POINTS-1:0] xprod_next;
    prod_t [NUM_POINTS-1:0] yprod_next;
    prod_t [NUM_POINTS-1:0] xprod_reg;
    prod_t [NUM_POINTS-1:0] yprod_reg;
    dot_t  [NUM_POINTS-1:0] dot;
    dot_t                   qmin_next;
    dot_t                   qmax_next;
    dot_t                   bmin_next;
    dot_t                   bmax_next;
    dot_t                   qmin_reg;
    dot_t                   qmax_reg;
    dot_t                   bmin_reg;
    dot_t                   bmax_reg;

    // one multiplier per point and coordinate, full width
    always_comb
    begin
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            xprod_next[i] = prod_t'($signed(pts_x[i])) * prod_t'(nx);
            yprod_next[i] = prod_t'($signed(pts_y[i])) * prod_t'(ny);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            dot[i] = dot_t'($signed(xprod_reg[i])) + dot_t'($signed(yprod_reg[i]));
        end
        qmin_next = dot_min(dot_min(dot[0], dot[1]), dot_min(dot[2], dot[3]));
        qmax_next = dot_max(dot_max(dot[0], dot[1]), dot_max(dot[2], dot[3]));
        bmin_next = dot_min(dot_min(dot[4], dot[5]), dot_min(dot[6], dot[7]));
        bmax_next = dot_max(dot_max(dot[4], dot[5]), dot_max(dot[6], dot[7]));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            xprod_reg <= xprod_next;
            yprod_reg <= yprod_next;
        end
        if (ctrl.load_range)
        begin
            qmin_reg <= qmin_next;
            qmax_reg <= qmax_next;
            bmin_reg <= bmin_next;
            bmax_reg <= bmax_next;
        end
    end

    // touching intervals overlap
    assign ok = !(qmax_reg < bmin_reg) && !(bmax_reg < qmin_reg);

endmodule
